// ===== rtl/rht_pkg.sv =====
`timescale 1ns / 1ps

package rht_pkg;

  localparam int DEPTH      = 16;
  localparam int ENTITY_LEN = 8;

  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CMP_W     = (CNT_W > 5) ? CNT_W : 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [63:0] KEY_MASK = (ENTITY_LEN >= 8) ? 64'hFFFF_FFFF_FFFF_FFFF :
                                     ((64'd1 << (8 * ENTITY_LEN)) - 64'd1);

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_KEEP = 1'd1;

  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_DUE   = 2'd2;

  localparam logic [1:0] MODE_DEFAULT = 2'd0;
  localparam logic [1:0] MODE_KEEP    = 2'd1;
  localparam logic [1:0] MODE_DROP    = 2'd2;
  localparam logic [1:0] MODE_UNKNOWN = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_BAD_MODE  = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_CPRD = 6'b000100,
    S_CPWR = 6'b001000,
    S_WR   = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

endpackage

// ===== rtl/retention_hold_table.sv =====
`timescale 1ns / 1ps

// Keyed table of retention holds.
// Requests arrive on in_valid/in_ready with one command each: set, query or
// due listing. Results leave on out_valid/out_ready; every request gives one
// result with last set, and a due listing first gives one result per listed
// key (is_summary 0) before its summary.
// capacity and default_keep are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle; it does not enforce this.
// Timing: in_ready is high only when idle; one request at a time. A request
// is accepted, then the occupied rows are scanned for the key or deadline,
// then a set writes its row back (a removal first reads the last row and
// copies it in), and last the result is loaded into the output register.
// The row memory read port sets the scan rate.
// A set with a bad field, a query with a bad key length or a bad command skips the scan.
// The output register lets the next request be accepted while the previous
// result waits. When the receiver stalls, a due listing pauses its scan.
// Reset (synchronous, rst high) empties the table at once by clearing the
// row count, sets capacity to 16 and default_keep to 0; no clearing pass.

module retention_hold_table (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rht_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [4:0]                         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         cmd,
  input  logic [63:0]                        entity,
  input  logic [7:0]                         key_len,
  input  logic [1:0]                         mode,
  input  logic [63:0]                        deadline,
  input  logic [1:0]                         next_mode,
  input  logic [63:0]                        now,
  input  logic [4:0]                         out_cap,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         status,
  output logic [1:0]                         retention,
  output logic                               keeps,
  output logic [63:0]                        due_entity,
  output logic                               is_summary,
  output logic [4:0]                         written_count,
  output logic [4:0]                         dropped_count,
  output logic [4:0]                         rows_used,
  output logic                               last
);

  import rht_pkg::*;

  logic [63:0] row_key        [DEPTH];
  logic [1:0]  row_mode       [DEPTH];
  logic [63:0] row_deadline   [DEPTH];
  logic [1:0]  row_after_mode [DEPTH];

  state_t state;

  logic [4:0]       capacity;
  logic             default_keep;
  logic [CNT_W-1:0] used;

  logic [1:0]  cmd_q;
  logic [63:0] key_q;
  logic [1:0]  mode_q;
  logic [63:0] dl_q;
  logic [1:0]  next_q;
  logic [63:0] now_q;
  logic [4:0]  cap_q;

  logic [CNT_W-1:0] ptr;
  logic             pv;
  logic [IDX_W-1:0] pidx;
  logic [IDX_W-1:0] widx;
  logic             wr_new;
  logic [4:0]       written;
  logic [CNT_W-1:0] dropped;
  logic [1:0]       res_status;
  logic [1:0]       res_ret;

  logic [63:0] rkey;
  logic [1:0]  rmode;
  logic [63:0] rdl;
  logic [1:0]  rafter;

  logic             out_free;
  logic             out_load;
  logic             hit;
  logic             due_hit;
  logic             emit_due;
  logic             stall;
  logic             scan_done;
  logic             full;
  logic             len_ok;
  logic [1:0]       hit_ret;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] last_idx;
  logic             wr_en;
  logic [63:0]      wr_key;
  logic [1:0]       wr_mode;
  logic [63:0]      wr_dl;
  logic [1:0]       wr_after;

  always_comb begin
    out_free  = !out_valid || out_ready;
    hit       = pv && (rkey == key_q);
    due_hit   = pv && (rdl != 64'd0) && (now_q >= rdl);
    emit_due  = (cmd_q == CMD_DUE) && due_hit && (written < cap_q);
    stall     = (state == S_SCAN) && emit_due && !out_free;
    out_load  = ((state == S_SCAN) && emit_due && !stall) || ((state == S_OUT) && out_free);
    scan_done = !pv && (ptr >= used);
    hit_ret   = ((rdl != 64'd0) && (now_q >= rdl)) ? rafter : rmode;
    len_ok    = (key_len == 8'(ENTITY_LEN));
    last_idx  = IDX_W'(used - CNT_W'(1));
    if (CMP_W'(capacity) > CMP_W'(DEPTH)) begin
      full = (used >= CNT_W'(DEPTH));
    end else begin
      full = (CMP_W'(used) >= CMP_W'(capacity));
    end
    if (state == S_CPRD) begin
      raddr = last_idx;
    end else if (!stall && (ptr < used)) begin
      raddr = ptr[IDX_W-1:0];
    end else begin
      raddr = pidx;
    end
    wr_en = (state == S_WR) || (state == S_CPWR);
    if (state == S_CPWR) begin
      wr_key   = rkey;
      wr_mode  = rmode;
      wr_dl    = rdl;
      wr_after = rafter;
    end else begin
      wr_key   = key_q;
      wr_mode  = mode_q;
      wr_dl    = dl_q;
      wr_after = (dl_q == 64'd0) ? MODE_DEFAULT : next_q;
    end
  end

  assign in_ready = (state == S_IDLE);

  // row memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_key[widx]        <= wr_key;
      row_mode[widx]       <= wr_mode;
      row_deadline[widx]   <= wr_dl;
      row_after_mode[widx] <= wr_after;
    end
    rkey   <= row_key[raddr];
    rmode  <= row_mode[raddr];
    rdl    <= row_deadline[raddr];
    rafter <= row_after_mode[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= 5'd16;
      default_keep <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAPACITY:     capacity     <= cfg_data;
        REG_DEFAULT_KEEP: default_keep <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
      pv        <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q      <= cmd;
            key_q      <= entity & KEY_MASK;
            mode_q     <= mode;
            dl_q       <= deadline;
            next_q     <= next_mode;
            now_q      <= now;
            cap_q      <= out_cap;
            ptr        <= '0;
            pv         <= 1'b0;
            written    <= '0;
            dropped    <= '0;
            res_ret    <= MODE_DEFAULT;
            case (cmd)
              CMD_SET: begin
                if (!len_ok) begin
                  res_status <= ST_MALFORMED;
                  state      <= S_OUT;
                end else if ((mode == MODE_UNKNOWN) || (next_mode == MODE_UNKNOWN)) begin
                  res_status <= ST_BAD_MODE;
                  state      <= S_OUT;
                end else if ((mode == MODE_DEFAULT) && (deadline != 64'd0)) begin
                  res_status <= ST_MALFORMED;
                  state      <= S_OUT;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_SCAN;
                end
              end
              CMD_QUERY: begin
                res_status <= ST_OK;
                if (len_ok) begin
                  state <= S_SCAN;
                end else begin
                  state <= S_OUT;
                end
              end
              CMD_DUE: begin
                res_status <= ST_OK;
                state      <= S_SCAN;
              end
              default: begin
                res_status <= ST_MALFORMED;
                state      <= S_OUT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!stall) begin
            pv <= (ptr < used);
            if (ptr < used) begin
              pidx <= ptr[IDX_W-1:0];
              ptr  <= CNT_W'(ptr + CNT_W'(1));
            end
          end
          case (cmd_q)
            CMD_DUE: begin
              if (!stall && due_hit) begin
                if (written < cap_q) begin
                  written       <= 5'(written + 5'd1);
                  status        <= ST_OK;
                  retention     <= MODE_DEFAULT;
                  keeps         <= 1'b0;
                  due_entity    <= rkey;
                  is_summary    <= 1'b0;
                  written_count <= '0;
                  dropped_count <= '0;
                  rows_used     <= 5'(used);
                  last          <= 1'b0;
                end else begin
                  dropped <= CNT_W'(dropped + CNT_W'(1));
                end
              end
              if (scan_done) begin
                state <= S_OUT;
              end
            end
            CMD_QUERY: begin
              if (hit) begin
                res_ret <= hit_ret;
                state   <= S_OUT;
              end else if (scan_done) begin
                state <= S_OUT;
              end
            end
            default: begin
              if (hit) begin
                widx   <= pidx;
                wr_new <= 1'b0;
                state  <= (mode_q == MODE_DEFAULT) ? S_CPRD : S_WR;
              end else if (scan_done) begin
                if (mode_q == MODE_DEFAULT) begin
                  state <= S_OUT;
                end else if (full) begin
                  res_status <= ST_FULL;
                  state      <= S_OUT;
                end else begin
                  widx   <= used[IDX_W-1:0];
                  wr_new <= 1'b1;
                  state  <= S_WR;
                end
              end
            end
          endcase
        end
        S_CPRD: begin
          state <= S_CPWR;
        end
        S_CPWR: begin
          used  <= CNT_W'(used - CNT_W'(1));
          state <= S_OUT;
        end
        S_WR: begin
          if (wr_new) begin
            used <= CNT_W'(used + CNT_W'(1));
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            status        <= res_status;
            retention     <= res_ret;
            if (cmd_q != CMD_QUERY) begin
              keeps <= 1'b0;
            end else if (res_ret == MODE_KEEP) begin
              keeps <= 1'b1;
            end else if (res_ret == MODE_DROP) begin
              keeps <= 1'b0;
            end else begin
              keeps <= default_keep;
            end
            due_entity    <= '0;
            is_summary    <= 1'b1;
            written_count <= written;
            dropped_count <= 5'(dropped);
            rows_used     <= 5'(used);
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(DEPTH))
    else $error("row count beyond table depth");

  a_scan_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && pv |-> (CNT_W'(pidx) < used))
    else $error("scan read beyond occupied rows");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) && wr_new |-> (used < CNT_W'(DEPTH)))
    else $error("insert into a full table");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_CPWR) |=> (used == CNT_W'($past(used) - CNT_W'(1))))
    else $error("remove did not shrink the table");

  a_last_summary: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == is_summary))
    else $error("last and summary flags disagree");

endmodule
